// File: sv/wrcw_pkg.sv
// ----------------------------------------------------------------------------
// WebP RIFF chunk walker package
// Shared types, tag constants and record codes for the chunk walker.
// ----------------------------------------------------------------------------
package wrcw_pkg;

  // Four-character tags, first character in bits 7:0.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
  localparam logic [31:0] TAG_VP8X = 32'h5838_5056;
  localparam logic [31:0] TAG_ANIM = 32'h4D49_4E41;

  // Shortest bodies that still carry the fields we extract.
  localparam logic [31:0] VP8X_MIN_SIZE = 32'd10;
  localparam logic [31:0] ANIM_MIN_SIZE = 32'd6;

  // Header lengths in bytes.
  localparam logic [3:0] TAG_BYTES = 4'd4;
  localparam logic [3:0] HDR_BYTES = 4'd8;

  // Body byte offsets that close a field capture, and the offset saturation value.
  localparam logic [3:0] VP8X_LAST_OFF = 4'd9;
  localparam logic [3:0] ANIM_LAST_OFF = 4'd5;
  localparam logic [3:0] OFF_SAT       = 4'd15;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_WEBP = 3'd1,
    PH_HDR  = 3'd2,
    PH_BODY = 3'd3,
    PH_HALT = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_VP8X  = 2'd1,
    CLS_ANIM  = 2'd2
  } chunk_class_e;

  typedef enum logic [2:0] {
    REC_RIFF_SIZE = 3'd0,
    REC_CHUNK     = 3'd1,
    REC_VP8X      = 3'd2,
    REC_ANIM      = 3'd3,
    REC_NOT_RIFF  = 3'd4,
    REC_NOT_WEBP  = 3'd5
  } rec_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  // Input stage contents handed to the parser.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } pend_t;

  typedef struct packed {
    logic [2:0]  rec_kind;
    logic [31:0] fourcc;
    logic [31:0] size_value;
    logic [4:0]  feature_flags;
    logic [24:0] canvas_width;
    logic [24:0] canvas_height;
    logic [31:0] background_bgra;
    logic [15:0] anim_loops;
  } result_t;

endpackage

// File: sv/wrcw_in_if.sv
// ----------------------------------------------------------------------------
// Byte stream channel
// Valid/ready channel carrying one file byte and its file start marker.
// ----------------------------------------------------------------------------
interface wrcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

// File: sv/wrcw_out_if.sv
// ----------------------------------------------------------------------------
// Record channel
// Valid/ready channel carrying one parsed container record.
// ----------------------------------------------------------------------------
interface wrcw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  rec_kind;
  logic [31:0] fourcc;
  logic [31:0] size_value;
  logic [4:0]  feature_flags;
  logic [24:0] canvas_width;
  logic [24:0] canvas_height;
  logic [31:0] background_bgra;
  logic [15:0] anim_loops;

  modport source (output valid, output rec_kind, output fourcc, output size_value,
                  output feature_flags, output canvas_width, output canvas_height,
                  output background_bgra, output anim_loops, input ready);
  modport sink   (input valid, input rec_kind, input fourcc, input size_value,
                  input feature_flags, input canvas_width, input canvas_height,
                  input background_bgra, input anim_loops, output ready);
endinterface

// File: sv/wrcw_in_reg.sv
// ----------------------------------------------------------------------------
// Chunk walker input register
// Holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wrcw_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  wrcw_pkg::in_item_t item_i,
  output logic              ready_o,
  input  logic              take_i,
  output wrcw_pkg::pend_t    pend_o
);
  import wrcw_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q,  item_d;

  // The stage is free when empty or when its byte leaves this cycle.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        item_d = item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign pend_o.valid = valid_q;
  assign pend_o.item  = item_q;

endmodule

// File: sv/wrcw_parser.sv
// ----------------------------------------------------------------------------
// Chunk walker parser
// Container parse state and the per-byte update that yields at most one record.
// ----------------------------------------------------------------------------
module wrcw_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  wrcw_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output wrcw_pkg::result_t   res_o
);
  import wrcw_pkg::*;

  phase_e       phase_q, phase_d, phase_b;
  logic [3:0]   pos_q, pos_d, pos_b, pos_n;
  logic [63:0]  shift_q, shift_d, shift_b, shift_n;
  logic [32:0]  remain_q, remain_d, remain_b, remain_n;
  logic [3:0]   offset_q, offset_d, offset_b, vp8x_idx;
  chunk_class_e cls_q, cls_d, cls_b;
  logic [55:0]  capture_q, capture_d, capture_b;
  logic [31:0]  lo, hi;
  logic         emit;
  result_t      res;

  function automatic result_t make_rec(rec_kind_e kind, logic [31:0] tag,
                                       logic [31:0] size);
    result_t r;
    r            = '0;
    r.rec_kind   = kind;
    r.fourcc     = tag;
    r.size_value = size;
    return r;
  endfunction

  // A file start marker restarts the parse from the reset state.
  always_comb begin
    if (item_i.file_start) begin
      phase_b   = PH_RIFF;
      pos_b     = '0;
      shift_b   = '0;
      remain_b  = '0;
      offset_b  = '0;
      cls_b     = CLS_OTHER;
      capture_b = '0;
    end else begin
      phase_b   = phase_q;
      pos_b     = pos_q;
      shift_b   = shift_q;
      remain_b  = remain_q;
      offset_b  = offset_q;
      cls_b     = cls_q;
      capture_b = capture_q;
    end
  end

  // Header bytes enter from the top of the shift register.
  assign shift_n  = {item_i.data_byte, shift_b[63:8]};
  assign pos_n    = pos_b + 4'd1;
  assign lo       = shift_n[31:0];
  assign hi       = shift_n[63:32];
  assign remain_n = remain_b - 33'd1;
  assign vp8x_idx = offset_b - 4'd3;

  // Next state and record for the byte in the input register.
  always_comb begin
    phase_d   = phase_b;
    pos_d     = pos_b;
    shift_d   = shift_b;
    remain_d  = remain_b;
    offset_d  = offset_b;
    cls_d     = cls_b;
    capture_d = capture_b;
    emit      = 1'b0;
    res       = '0;
    unique case (phase_b)
      PH_WEBP: begin
        shift_d = shift_n;
        pos_d   = pos_n;
        if (pos_n >= TAG_BYTES) begin
          pos_d = '0;
          if (hi != TAG_WEBP) begin
            phase_d = PH_HALT;
            emit    = 1'b1;
            res     = make_rec(REC_NOT_WEBP, hi, '0);
          end else begin
            phase_d = PH_HDR;
          end
        end
      end
      PH_RIFF: begin
        shift_d = shift_n;
        pos_d   = pos_n;
        if (pos_n >= HDR_BYTES) begin
          pos_d = '0;
          emit  = 1'b1;
          if (lo != TAG_RIFF) begin
            phase_d = PH_HALT;
            res     = make_rec(REC_NOT_RIFF, lo, '0);
          end else if (hi == '0) begin
            phase_d = PH_HALT;
            res     = make_rec(REC_NOT_WEBP, lo, '0);
          end else begin
            phase_d = PH_WEBP;
            res     = make_rec(REC_RIFF_SIZE, lo, hi);
          end
        end
      end
      PH_HDR: begin
        shift_d = shift_n;
        pos_d   = pos_n;
        if (pos_n >= HDR_BYTES) begin
          pos_d = '0;
          priority if (lo == TAG_VP8X && hi >= VP8X_MIN_SIZE) begin
            cls_d = CLS_VP8X;
          end else if (lo == TAG_ANIM && hi >= ANIM_MIN_SIZE) begin
            cls_d = CLS_ANIM;
          end else begin
            cls_d = CLS_OTHER;
          end
          // Odd bodies carry one pad byte.
          remain_d  = {1'b0, hi} + {32'd0, hi[0]};
          offset_d  = '0;
          capture_d = '0;
          phase_d   = (hi != '0) ? PH_BODY : PH_HDR;
          emit      = 1'b1;
          res       = make_rec(REC_CHUNK, lo, hi);
        end
      end
      PH_BODY: begin
        if (offset_b != OFF_SAT) begin
          offset_d = offset_b + 4'd1;
        end
        remain_d = remain_n;
        if (remain_n == '0) begin
          phase_d = PH_HDR;
        end
        unique case (cls_b)
          CLS_VP8X: begin
            if (offset_b == '0) begin
              capture_d[7:0] = capture_b[7:0] | item_i.data_byte;
            end else if (offset_b >= 4'd4 && offset_b <= VP8X_LAST_OFF) begin
              capture_d[{vp8x_idx[2:0], 3'b000} +: 8] =
                capture_b[{vp8x_idx[2:0], 3'b000} +: 8] | item_i.data_byte;
            end
            if (offset_b == VP8X_LAST_OFF) begin
              emit                = 1'b1;
              res                 = make_rec(REC_VP8X, TAG_VP8X, '0);
              res.feature_flags   = capture_d[5:1];
              res.canvas_width    = {1'b0, capture_d[31:8]} + 25'd1;
              res.canvas_height   = {1'b0, capture_d[55:32]} + 25'd1;
            end
          end
          CLS_ANIM: begin
            if (offset_b <= ANIM_LAST_OFF) begin
              capture_d[{offset_b[2:0], 3'b000} +: 8] =
                capture_b[{offset_b[2:0], 3'b000} +: 8] | item_i.data_byte;
            end
            if (offset_b == ANIM_LAST_OFF) begin
              emit                = 1'b1;
              res                 = make_rec(REC_ANIM, TAG_ANIM, '0);
              res.background_bgra = capture_d[31:0];
              res.anim_loops      = capture_d[47:32];
            end
          end
          default: begin
            // Other chunk bodies are skipped.
          end
        endcase
      end
      default: begin
        // Halted after an error, or a phase code with no meaning.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_RIFF;
      pos_q     <= '0;
      shift_q   <= '0;
      remain_q  <= '0;
      offset_q  <= '0;
      cls_q     <= CLS_OTHER;
      capture_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      shift_q   <= shift_d;
      remain_q  <= remain_d;
      offset_q  <= offset_d;
      cls_q     <= cls_d;
      capture_q <= capture_d;
    end
  end

  assign res_valid_o = step_i && emit;
  assign res_o       = res;

endmodule

// File: sv/wrcw_out_reg.sv
// ----------------------------------------------------------------------------
// Chunk walker output register
// Holds one record until the receiver takes it.
// ----------------------------------------------------------------------------
module wrcw_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  wrcw_pkg::result_t  res_i,
  input  logic              ready_i,
  output logic              valid_o,
  output wrcw_pkg::result_t  res_o,
  output logic              free_o
);
  import wrcw_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q,   res_d;

  // The register may take a new record when empty or being drained.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (free_o) begin
      valid_d = load_i;
      if (load_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: sv/webp_riff_chunk_walker_unit.sv
// ----------------------------------------------------------------------------
// WebP RIFF chunk walker
// Walks a WebP container one byte per transaction and reports its records.
// ----------------------------------------------------------------------------
// The item_i channel takes one file byte per transaction; file_start marks the
// first byte of a file and restarts the parse. The result_o channel gives one
// record per transaction: the RIFF size, each chunk header, VP8X canvas
// information, ANIM background information, or an error for a bad RIFF or
// WEBP tag or a zero RIFF size, after which bytes are ignored until the next
// file start. One byte is taken every cycle while the receiver keeps up. A
// byte is held in the input register, is parsed by the logic after it and any
// record is loaded into the output register once that register is free.
// The single parse stage sustains one byte per cycle unless the receiver stalls.
// When the receiver stalls, the record waits in the output register while one
// further byte is still taken into the input register; after that item_i
// ready drops until the record is taken. Reset empties both registers and
// puts the walker back to awaiting the RIFF header.
// ----------------------------------------------------------------------------
module webp_riff_chunk_walker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  wrcw_in_if.sink    item_i,
  wrcw_out_if.source result_o
);
  import wrcw_pkg::*;

  in_item_t in_item;
  pend_t    pend;
  logic     take;
  logic     out_free;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.data_byte  = item_i.data_byte;
  assign in_item.file_start = item_i.file_start;

  // Input register.
  wrcw_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_i.valid),
    .item_i  (in_item),
    .ready_o (item_i.ready),
    .take_i  (take),
    .pend_o  (pend)
  );

  // A held byte is parsed whenever the output register can take its record.
  assign take = pend.valid && out_free;

  wrcw_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .item_i      (pend.item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register.
  wrcw_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (result_o.ready),
    .valid_o (result_o.valid),
    .res_o   (out_res),
    .free_o  (out_free)
  );

  assign result_o.rec_kind        = out_res.rec_kind;
  assign result_o.fourcc          = out_res.fourcc;
  assign result_o.size_value      = out_res.size_value;
  assign result_o.feature_flags   = out_res.feature_flags;
  assign result_o.canvas_width    = out_res.canvas_width;
  assign result_o.canvas_height   = out_res.canvas_height;
  assign result_o.background_bgra = out_res.background_bgra;
  assign result_o.anim_loops      = out_res.anim_loops;

  // A byte held in the input register and not parsed blocks the input channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend.valid && !take |-> !item_i.ready)
    else $error("input accepted while the held byte is stalled");

  // A new record only appears after a byte was parsed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !$past(result_o.valid) |-> $past(take))
    else $error("record appeared without a parsed byte");

  // Records only carry defined kinds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.rec_kind <= REC_NOT_WEBP)
    else $error("record kind out of range");

endmodule

// File: test/tb_webp_riff_chunk_walker_unit.sv
// ----------------------------------------------------------------------------
// WebP RIFF chunk walker testbench
// Feeds the walker short directed byte streams and then many random WebP
// files, mostly well formed with random content and some broken, cut short
// or pure noise. A behavioural walker inside the bench predicts the records
// not typed in the directed rows; each record transaction is checked field by
// field against the oldest one, under sender gap and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_webp_riff_chunk_walker_unit;
  import wrcw_pkg::*;

  // The watchdog limit covers the slowest correct run: about 1000 bytes, each
  // with a random sender gap and receiver stall.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One row of the directed byte stream, with its record where one is obvious.
  typedef struct packed {
    logic [7:0]  data;
    logic        fs;
    logic        typed;
    logic [2:0]  kind;
    logic [31:0] fourcc;
    logic [31:0] rec_size;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;
  localparam script_row_t SCRIPT_TAB [SCRIPT_LEN] = '{
    // A RIFF header with a zero size is refused.
    '{data: 8'h52, fs: 1'b1, default: '0},
    '{data: 8'h49, fs: 1'b0, default: '0},
    '{data: 8'h46, fs: 1'b0, default: '0},
    '{data: 8'h46, fs: 1'b0, default: '0},
    '{data: 8'h00, fs: 1'b0, default: '0},
    '{data: 8'h00, fs: 1'b0, default: '0},
    '{data: 8'h00, fs: 1'b0, default: '0},
    '{data: 8'h00, fs: 1'b0, typed: 1'b1, kind: REC_NOT_WEBP, fourcc: TAG_RIFF,
      rec_size: 32'h0},
    // A new file with the largest RIFF size.
    '{data: 8'h52, fs: 1'b1, default: '0},
    '{data: 8'h49, fs: 1'b0, default: '0},
    '{data: 8'h46, fs: 1'b0, default: '0},
    '{data: 8'h46, fs: 1'b0, default: '0},
    '{data: 8'hFF, fs: 1'b0, default: '0},
    '{data: 8'hFF, fs: 1'b0, default: '0},
    '{data: 8'hFF, fs: 1'b0, default: '0},
    '{data: 8'hFF, fs: 1'b0, typed: 1'b1, kind: REC_RIFF_SIZE, fourcc: TAG_RIFF,
      rec_size: 32'hFFFF_FFFF},
    '{data: 8'h57, fs: 1'b0, default: '0},
    '{data: 8'h45, fs: 1'b0, default: '0},
    '{data: 8'h42, fs: 1'b0, default: '0},
    '{data: 8'h50, fs: 1'b0, default: '0},
    // An empty ANIM chunk: header record only, straight on to the next header.
    '{data: 8'h41, fs: 1'b0, default: '0},
    '{data: 8'h4E, fs: 1'b0, default: '0},
    '{data: 8'h49, fs: 1'b0, default: '0},
    '{data: 8'h4D, fs: 1'b0, default: '0},
    '{data: 8'h00, fs: 1'b0, default: '0},
    '{data: 8'h00, fs: 1'b0, default: '0},
    '{data: 8'h00, fs: 1'b0, default: '0},
    '{data: 8'h00, fs: 1'b0, typed: 1'b1, kind: REC_CHUNK, fourcc: TAG_ANIM,
      rec_size: 32'h0}
  };

  logic clk_i;
  logic rst_ni;

  wrcw_in_if  byte_if ();
  wrcw_out_if rec_if ();

  webp_riff_chunk_walker_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (byte_if),
    .result_o (rec_if)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Walker state as predicted by the bench.
  phase_e       walk_phase;
  logic [3:0]   hdr_count;
  logic [63:0]  hdr_bytes;
  logic [32:0]  body_left;
  logic [3:0]   body_idx;
  chunk_class_e body_class;
  logic [55:0]  body_fields;

  result_t     pending_recs [$];
  logic [8:0]  stream_q [$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned live_bytes = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        typed_now = 1'b0;
  result_t     typed_rec = '0;

  function automatic void reset_walk();
    walk_phase  = PH_RIFF;
    hdr_count   = '0;
    hdr_bytes   = '0;
    body_left   = '0;
    body_idx    = '0;
    body_class  = CLS_OTHER;
    body_fields = '0;
  endfunction

  // Advances the predicted walker by one byte and gives any record it causes.
  function automatic void walk_byte(input logic [7:0] b, input logic fs,
                                    output logic got, output result_t rec);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [3:0]  off;
    got = 1'b0;
    rec = '0;
    if (fs) reset_walk();
    case (walk_phase)
      PH_RIFF, PH_WEBP, PH_HDR: begin
        hdr_bytes = {b, hdr_bytes[63:8]};
        hdr_count = hdr_count + 4'd1;
        lo = hdr_bytes[31:0];
        hi = hdr_bytes[63:32];
        if (walk_phase == PH_WEBP) begin
          if (hdr_count >= TAG_BYTES) begin
            hdr_count = '0;
            if (hi != TAG_WEBP) begin
              walk_phase   = PH_HALT;
              got          = 1'b1;
              rec.rec_kind = REC_NOT_WEBP;
              rec.fourcc   = hi;
            end else begin
              walk_phase = PH_HDR;
            end
          end
        end else if (hdr_count >= HDR_BYTES) begin
          hdr_count  = '0;
          got        = 1'b1;
          rec.fourcc = lo;
          if (walk_phase == PH_RIFF) begin
            if (lo != TAG_RIFF) begin
              walk_phase   = PH_HALT;
              rec.rec_kind = REC_NOT_RIFF;
            end else if (hi == 32'h0) begin
              walk_phase   = PH_HALT;
              rec.rec_kind = REC_NOT_WEBP;
            end else begin
              walk_phase     = PH_WEBP;
              rec.rec_kind   = REC_RIFF_SIZE;
              rec.size_value = hi;
            end
          end else begin
            // Chunk header: odd sizes carry one pad byte after the body.
            if (lo == TAG_VP8X && hi >= VP8X_MIN_SIZE) body_class = CLS_VP8X;
            else if (lo == TAG_ANIM && hi >= ANIM_MIN_SIZE) body_class = CLS_ANIM;
            else body_class = CLS_OTHER;
            body_left      = {1'b0, hi} + {32'h0, hi[0]};
            body_idx       = '0;
            body_fields    = '0;
            walk_phase     = (body_left != 33'h0) ? PH_BODY : PH_HDR;
            rec.rec_kind   = REC_CHUNK;
            rec.size_value = hi;
          end
        end
      end
      PH_BODY: begin
        off = body_idx;
        if (body_idx < OFF_SAT) body_idx = body_idx + 4'd1;
        body_left = body_left - 33'd1;
        if (body_left == 33'h0) walk_phase = PH_HDR;
        if (body_class == CLS_VP8X) begin
          // Flags byte first, then the two 24-bit canvas fields.
          if (off == 4'd0) body_fields[7:0] = b;
          else if (off >= 4'd4 && off <= VP8X_LAST_OFF) body_fields[8*(off-3) +: 8] = b;
          if (off == VP8X_LAST_OFF) begin
            got               = 1'b1;
            rec.rec_kind      = REC_VP8X;
            rec.fourcc        = TAG_VP8X;
            rec.feature_flags = body_fields[5:1];
            rec.canvas_width  = {1'b0, body_fields[31:8]} + 25'd1;
            rec.canvas_height = {1'b0, body_fields[55:32]} + 25'd1;
          end
        end else if (body_class == CLS_ANIM) begin
          if (off <= ANIM_LAST_OFF) body_fields[8*off +: 8] = b;
          if (off == ANIM_LAST_OFF) begin
            got                 = 1'b1;
            rec.rec_kind        = REC_ANIM;
            rec.fourcc          = TAG_ANIM;
            rec.background_bgra = body_fields[31:0];
            rec.anim_loops      = body_fields[47:32];
          end
        end
      end
      default: begin
        // Halted, or a phase with no meaning: the byte is ignored.
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      fault_count++;
    end
  endtask

  // Samples both channels at the rising edge: checks each record transaction
  // and predicts the records of each byte transaction.
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    result_t next;
    logic    has;
    if (!rst_ni) begin
      reset_walk();
      pending_recs.delete();
    end else begin
      if (rec_if.valid && rec_if.ready) begin
        seen = '{rec_if.rec_kind, rec_if.fourcc, rec_if.size_value, rec_if.feature_flags,
                 rec_if.canvas_width, rec_if.canvas_height, rec_if.background_bgra,
                 rec_if.anim_loops};
        if (pending_recs.size() == 0) begin
          $display("%0t: record mismatch, expected none, actual kind %h fourcc %h",
                   $time, seen.rec_kind, seen.fourcc);
          fault_count++;
        end else begin
          want = pending_recs.pop_front();
          check_field("rec_kind", want.rec_kind, seen.rec_kind);
          check_field("fourcc", want.fourcc, seen.fourcc);
          check_field("size_value", want.size_value, seen.size_value);
          check_field("feature_flags", want.feature_flags, seen.feature_flags);
          check_field("canvas_width", want.canvas_width, seen.canvas_width);
          check_field("canvas_height", want.canvas_height, seen.canvas_height);
          check_field("background_bgra", want.background_bgra, seen.background_bgra);
          check_field("anim_loops", want.anim_loops, seen.anim_loops);
        end
      end
      if (byte_if.valid && byte_if.ready) begin
        walk_byte(byte_if.data_byte, byte_if.file_start, has, next);
        if (typed_now) pending_recs.push_back(typed_rec);
        else if (has) pending_recs.push_back(next);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Record receiver: ready changes at the falling edge only.
  initial begin
    rec_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rec_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one byte transaction, after any random gap, and waits for it.
  task automatic send_byte(input logic [8:0] item);
    while ($urandom_range(99) < idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= item[7:0];
    byte_if.file_start <= item[8];
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) stream_q.push_back({1'b0, w[8*i +: 8]});
  endtask

  // Builds one random file in stream_q: mostly well formed, sometimes with a
  // bad tag or zero size, cut short, or just noise.
  task automatic build_file();
    int unsigned style;
    int unsigned body;
    int unsigned keep;
    logic        broken;
    logic        huge;
    logic [31:0] tag;
    logic [31:0] sz;
    stream_q.delete();
    style = $urandom_range(99);
    if (style < 6) begin
      repeat ($urandom_range(1, 12))
        stream_q.push_back({($urandom_range(7) == 0), 8'($urandom)});
      live_bytes += stream_q.size();
    end else begin
      broken = (style < 16);
      tag = TAG_RIFF;
      if (style < 12) tag = tag ^ (32'h1 << $urandom_range(31));
      push_word(tag);
      if (style < 16) sz = 32'h0;
      else begin
        case ($urandom_range(3))
          0: sz = 32'h1;
          1: sz = 32'hFFFF_FFFF;
          default: sz = $urandom;
        endcase
      end
      push_word(sz);
      if (!broken) begin
        tag = TAG_WEBP;
        if (style < 22) begin
          tag    = tag ^ (32'h1 << $urandom_range(31));
          broken = 1'b1;
        end
        push_word(tag);
      end
      if (!broken) begin
        for (int c = $urandom_range(1, 4); c > 0; c--) begin
          huge = ($urandom_range(19) == 0);
          case ($urandom_range(2))
            0: begin
              tag = TAG_VP8X;
              sz  = ($urandom_range(6) == 0) ? $urandom_range(0, 9) : $urandom_range(10, 14);
            end
            1: begin
              tag = TAG_ANIM;
              sz  = ($urandom_range(6) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 9);
            end
            default: begin
              tag = ($urandom_range(7) == 0) ? TAG_RIFF : $urandom;
              sz  = $urandom_range(0, 7);
            end
          endcase
          // A huge chunk is only started; the next file cuts it off.
          if (huge) sz = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
          push_word(tag);
          push_word(sz);
          body = huge ? $urandom_range(10, 40) : sz + sz[0];
          repeat (body) stream_q.push_back({1'b0, 8'($urandom)});
          if (huge) break;
        end
      end
      if ($urandom_range(9) == 0) begin
        keep = $urandom_range(1, stream_q.size());
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end
      live_bytes += stream_q.size();
      // Bytes after an error are ignored by the walker and not counted.
      if (broken)
        repeat ($urandom_range(0, 4)) stream_q.push_back({1'b0, 8'($urandom)});
      if ($urandom_range(19) != 0) stream_q[0][8] = 1'b1;
    end
  endtask

  // Main sequence: reset, directed stream, random files, drain.
  initial begin
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = 8'h00;
    byte_if.file_start = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      typed_now = SCRIPT_TAB[i].typed;
      typed_rec = '0;
      typed_rec.rec_kind   = SCRIPT_TAB[i].kind;
      typed_rec.fourcc     = SCRIPT_TAB[i].fourcc;
      typed_rec.size_value = SCRIPT_TAB[i].rec_size;
      send_byte({SCRIPT_TAB[i].fs, SCRIPT_TAB[i].data});
    end
    typed_now = 1'b0;

    // Four traffic patterns: none, sender gaps, receiver stalls, both.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      live_bytes = 0;
      while (live_bytes < PHASE_BYTES) begin
        build_file();
        while (stream_q.size() != 0) send_byte(stream_q.pop_front());
      end
    end
    byte_if.valid <= 1'b0;

    while (pending_recs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/wrcw_pkg.sv
sv/wrcw_in_if.sv
sv/wrcw_out_if.sv
sv/wrcw_in_reg.sv
sv/wrcw_parser.sv
sv/wrcw_out_reg.sv
sv/webp_riff_chunk_walker_unit.sv
test/tb_webp_riff_chunk_walker_unit.sv
